// ----- hdl/masked_byte_pattern_scan_top_defines.svh -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_top_defines
// assertion macros shared by the pattern scan rtl
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define MBPS_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mbps assertion failed");
// checked property, also evaluated during reset
`define MBPS_ASSERT_RST(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("mbps reset assertion failed");
`else
`define MBPS_ASSERT(name, clk, rstn, prop)
`define MBPS_ASSERT_RST(name, clk, prop)
`endif

`endif

// ----- hdl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// shared types and constants of the masked byte pattern scanner
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_OFFSET_BITS       = 32;

    // pattern bytes held by the two pattern registers
    localparam int PAT_REG_BYTES = 16;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int ADDR_W       = 64;
    localparam int COUNT_W      = 16;
    localparam int PLEN_W       = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_MATCH_INDEX    = 3'd4,
        REG_BASE_ADDRESS   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [63:0]          pattern_low;
        logic [63:0]          pattern_high;
        logic [15:0]          care_mask;
        logic [PLEN_W-1:0]    pattern_length;
        logic [COUNT_W-1:0]   match_index;
        logic [ADDR_W-1:0]    base_address;
    } cfg_t;

endpackage

// ----- hdl/mbps_cfg.sv -----
// ----------------------------------------------------------------------------
// mbps_cfg
// configuration register file, written by index
// ----------------------------------------------------------------------------
module mbps_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    output mbps_pkg::cfg_t                       cfg
);
    import mbps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_LOW:    cfg_next.pattern_low    = cfg_wr_data;
                REG_PATTERN_HIGH:   cfg_next.pattern_high   = cfg_wr_data;
                REG_CARE_MASK:      cfg_next.care_mask      = cfg_wr_data[15:0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_wr_data[PLEN_W-1:0];
                REG_MATCH_INDEX:    cfg_next.match_index    = cfg_wr_data[COUNT_W-1:0];
                REG_BASE_ADDRESS:   cfg_next.base_address   = cfg_wr_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.care_mask      <= 16'hFFFF;
            cfg_reg.pattern_length <= PLEN_W'(1);
            cfg_reg.match_index    <= '0;
            cfg_reg.base_address   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/mbps_window.sv -----
// ----------------------------------------------------------------------------
// mbps_window
// byte window shift line with fill count and parallel masked compare
// ----------------------------------------------------------------------------
module mbps_window #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic              region_clear,
    input  logic [7:0]        data_byte,
    input  mbps_pkg::cfg_t    cfg,
    output logic              match,
    output logic [LEN_W-1:0]  len_eff
);
    import mbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [7:0]              win_reg [MAX_PATTERN_BYTES];
    logic [7:0]              win_next [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]        fill_reg;
    logic [LEN_W-1:0]        fill_next;
    logic [LEN_W-1:0]        fill_inc;
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;
    logic [8*PAT_REG_BYTES-1:0]   pattern;

    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    // zero length acts as one, oversize clamps to the window depth
    always_comb begin
        if (cfg.pattern_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(cfg.pattern_length) > MAX_PATTERN_BYTES) begin
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = LEN_W'(cfg.pattern_length);
        end
    end

    always_comb begin
        win_next[0] = data_byte;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
            win_next[j] = win_reg[j-1];
        end
    end

    assign fill_inc = (fill_reg == LEN_W'(MAX_PATTERN_BYTES)) ? fill_reg
                                                                : fill_reg + LEN_W'(1);

    // pattern byte k lines up with the byte received len-1-k transactions ago
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cmp
        logic [LEN_W-1:0] pos_full;
        logic [IDX_W-1:0] pos;
        logic             active;
        logic             cared;
        logic [7:0]       pbyte;

        assign active   = LEN_W'(k) < len_eff;
        assign pos_full = len_eff - LEN_W'(k) - LEN_W'(1);
        assign pos      = pos_full[IDX_W-1:0];

        if (k < PAT_REG_BYTES) begin : g_pat
            assign cared = cfg.care_mask[k];
            assign pbyte = pattern[8*k +: 8];
        end else begin : g_wild
            assign cared = 1'b0;
            assign pbyte = 8'h00;
        end

        assign byte_ok[k] = !active || !cared || (win_next[pos] == pbyte);
    end

    assign match = (fill_inc >= len_eff) && (&byte_ok);

    always_comb begin
        fill_next = fill_reg;
        if (region_clear) begin
            fill_next = '0;
        end else if (shift_en) begin
            fill_next = fill_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg <= win_next;
        end
    end

endmodule

// ----- hdl/masked_byte_pattern_scan_top.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_top
// wildcard byte pattern search over one region, one byte per transaction
// data path: an accepted byte goes through the input register, then the compare
//   and result register; the window compare is a single parallel pass
// throughput: one byte per cycle while the result slot is not held by m_ready
// reset: aresetn synchronous; config returns to defaults, region state clears
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scan_top_defines.svh"

module masked_byte_pattern_scan_top #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = mbps_pkg::DEF_OFFSET_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_last_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [mbps_pkg::ADDR_W-1:0]          m_match_address
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    cfg_t                  cfg;

    logic                  in_valid_reg;
    logic [7:0]            in_data_reg;
    logic                  in_last_reg;

    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic                   done_reg;
    logic                   done_next;

    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [ADDR_W-1:0]     m_addr_reg;

    logic                  process;
    logic                  shift_en;
    logic                  region_clear;
    logic                  match;
    logic [LEN_W-1:0]      len_eff;
    logic                  hit;
    logic                  sel;
    logic                  res_valid;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [ADDR_W-1:0]     res_addr;

    mbps_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    mbps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .shift_en     (shift_en),
        .region_clear (region_clear),
        .data_byte    (in_data_reg),
        .cfg          (cfg),
        .match        (match),
        .len_eff      (len_eff)
    );

    // the held byte moves on whenever the result slot is free or draining
    assign process      = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready      = !in_valid_reg || process;
    assign shift_en     = process && !done_reg;
    assign region_clear = process && in_last_reg;

    assign hit       = shift_en && match;
    assign sel       = hit && (count_reg == cfg.match_index);
    assign res_valid = shift_en && (sel || in_last_reg);

    assign start_offset = offset_reg - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1);
    assign res_addr     = cfg.base_address + ADDR_W'(start_offset);

    always_comb begin
        offset_next = offset_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        if (region_clear) begin
            offset_next = '0;
            count_next  = '0;
            done_next   = 1'b0;
        end else begin
            if (shift_en) begin
                offset_next = offset_reg + OFFSET_BITS'(1);
            end
            if (sel) begin
                done_next = 1'b1;
            end else if (hit && (count_reg != '1)) begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            offset_reg   <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            offset_reg <= offset_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            if (process && res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (process && res_valid) begin
            m_found_reg <= sel;
            m_addr_reg  <= sel ? res_addr : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_match_address = m_addr_reg;

    `MBPS_ASSERT_RST(a_reset_clears, aclk, !aresetn |=> !m_valid_reg && !in_valid_reg && !done_reg)
    `MBPS_ASSERT(a_notfound_on_last, aclk, aresetn, res_valid && !sel |-> in_last_reg)
    `MBPS_ASSERT(a_notfound_addr_zero, aclk, aresetn, m_valid_reg && !m_found_reg |-> m_addr_reg == '0)
    `MBPS_ASSERT(a_found_sets_done, aclk, aresetn, sel && !in_last_reg |=> done_reg)
    `MBPS_ASSERT(a_silent_when_done, aclk, aresetn, done_reg |-> !res_valid && !hit)

endmodule
